// File: src/gwf_pkg.sv
// Shared types and constants for the grid wall finder.
`default_nettype none
package gwf_pkg;

	// Field widths fixed by the interface
	localparam int REG_W     = 11;
	localparam int OUT_W     = 12;
	localparam int CELL_W    = 8;
	localparam int CFG_IDX_W = 2;

	// Cell code that counts as occupied
	localparam logic signed [CELL_W-1:0] OCC_CODE = 8'sd100;

	// Count saturation value
	localparam logic [REG_W-1:0] CNT_MAX = 11'h7FF;

	// Register reset values
	localparam logic [REG_W-1:0] GRID_WIDTH_RST = 11'd256;
	localparam logic [REG_W-1:0] COURSE_RST     = 11'd0;
	localparam logic [REG_W-1:0] ACCEPT_RST     = 11'd0;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH = 2'd0,
		REG_COURSE_LEN = 2'd1,
		REG_WALL_ACCEPT = 2'd2
	} gwf_reg_t;

	// Sequencer states
	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_WR    = 9'b000000100,
		ST_RND   = 9'b000001000,
		ST_LO    = 9'b000010000,
		ST_HI    = 9'b000100000,
		ST_FIN   = 9'b001000000,
		ST_SPARE = 9'b010000000,
		ST_HOLD  = 9'b100000000
	} gwf_state_t;

endpackage
`default_nettype wire

// File: src/grid_wall_finder_core.sv
// Grid wall finder: row/column occupancy counts and two-ended wall search.
//
// Usage: cells of a square grid arrive in row-major order on cell_value /
// last_cell; an item is taken at a clock edge with start high and busy low.
// Each cell passes through an accept step and then a read-modify-write of
// the column count memory, so a new cell is taken only after that write.
// After the item marked last_cell the block searches the row counts and
// then the column counts with one shared compare unit, from both ends in
// turn. Each search round visits ST_RND, ST_LO and ST_HI (one memory read
// per end); once one end has found its wall the other goes on alone.
// The result is shown for exactly one cycle with done high; the receiver
// cannot stall it. After the result the column counts are cleared, one
// entry a cycle, over the highest column index used in that grid plus one.
// Reset clears the control state and starts a clearing pass over all
// MAX_GRID entries of the column count memory; busy stays high until it ends.
// Configuration is written through cfg_valid/cfg_ready (always ready) with
// cfg_index selecting grid_width, course_length_cells or wall_accept_cells,
// and is meant to be written only while the block is idle.
`default_nettype none
module grid_wall_finder_core import gwf_pkg::*; #(
	parameter int MAX_GRID = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// cell channel
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic signed [CELL_W-1:0]   cell_value,
	input  wire logic                       last_cell,
	// result channel
	output logic                            done,
	output logic signed [OUT_W-1:0]         north_row,
	output logic                            north_ok,
	output logic signed [OUT_W-1:0]         south_row,
	output logic                            south_ok,
	output logic signed [OUT_W-1:0]         east_col,
	output logic                            east_ok,
	output logic signed [OUT_W-1:0]         west_col,
	output logic                            west_ok,
	// configuration channel
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [REG_W-1:0]           cfg_data
);

	localparam int IDXW = $clog2(MAX_GRID);
	localparam int WW   = (IDXW + 1 > REG_W) ? IDXW + 1 : REG_W;

	gwf_state_t state_q;

	// configuration registers
	logic [REG_W-1:0] grid_width_q;
	logic [REG_W-1:0] course_q;
	logic [REG_W-1:0] accept_q;

	// streaming state
	logic [IDXW-1:0]  cur_row_q;
	logic [IDXW-1:0]  cur_col_q;
	logic [REG_W-1:0] row_accum_q;
	logic             occ_q;
	logic             last_q;
	logic [IDXW-1:0]  hwm_q;
	logic [IDXW-1:0]  clr_q;

	// search state
	logic             sel_col_q;
	logic [IDXW-1:0]  lo_q;
	logic [IDXW-1:0]  hi_q;
	logic [REG_W-1:0] lo_peak_q;
	logic [REG_W-1:0] hi_peak_q;
	logic             lf_q;
	logic             hf_q;
	logic [OUT_W-1:0] lo_wall_q;
	logic [OUT_W-1:0] hi_wall_q;

	// result registers
	logic             done_q;
	logic [OUT_W-1:0] north_q;
	logic             north_ok_q;
	logic [OUT_W-1:0] south_q;
	logic             south_ok_q;
	logic [OUT_W-1:0] east_q;
	logic             east_ok_q;
	logic [OUT_W-1:0] west_q;
	logic             west_ok_q;

	// count memories
	logic [REG_W-1:0] col_mem [MAX_GRID];
	logic [REG_W-1:0] row_mem [MAX_GRID];
	logic [REG_W-1:0] col_rd_q;
	logic [REG_W-1:0] row_rd_q;

	logic             col_we;
	logic [IDXW-1:0]  col_wa;
	logic [REG_W-1:0] col_wd;
	logic [IDXW-1:0]  col_ra;
	logic             row_we;
	logic [IDXW-1:0]  srch_addr;

	logic [WW-1:0]    weff;
	logic [WW-1:0]    col_next;
	logic [WW-1:0]    row_next;
	logic             row_end;
	logic             accept;
	logic             srch_go;

	logic [REG_W-1:0] cmp_cnt;
	logic [REG_W-1:0] cmp_peak;
	logic             cmp_gt;
	logic             cmp_fall;

	logic [OUT_W-1:0] fin_lo;
	logic [OUT_W-1:0] fin_hi;
	logic             fin_ok;

	// effective width, clamped to 2..MAX_GRID
	always_comb begin
		if (WW'(grid_width_q) < WW'(2)) begin
			weff = WW'(2);
		end else if (WW'(grid_width_q) > WW'(MAX_GRID)) begin
			weff = WW'(MAX_GRID);
		end else begin
			weff = WW'(grid_width_q);
		end
	end

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign col_next  = WW'(cur_col_q) + WW'(1);
	assign row_next  = WW'(cur_row_q) + WW'(1);
	assign row_end   = last_q || (col_next >= weff);
	assign srch_go   = (!lf_q || !hf_q) && (lo_q < hi_q);

	// search read address: lo end first in a round, then hi end
	always_comb begin
		if (state_q == ST_RND && !lf_q) begin
			srch_addr = lo_q;
		end else begin
			srch_addr = hi_q;
		end
	end

	// column memory port control: clearing sweep or count update
	assign col_we = (state_q == ST_CLEAR) || ((state_q == ST_WR) && occ_q);
	assign col_wa = (state_q == ST_CLEAR) ? clr_q : cur_col_q;
	assign col_wd = (state_q == ST_CLEAR) ? '0 :
		((col_rd_q == CNT_MAX) ? col_rd_q : col_rd_q + REG_W'(1));
	assign col_ra = (state_q == ST_IDLE) ? cur_col_q : srch_addr;
	assign row_we = (state_q == ST_WR) && row_end;

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_wa] <= col_wd;
		end
		col_rd_q <= col_mem[col_ra];
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[cur_row_q] <= row_accum_q;
		end
		row_rd_q <= row_mem[srch_addr];
	end

	// shared compare unit for both ends and both passes
	assign cmp_cnt  = sel_col_q ? col_rd_q : row_rd_q;
	assign cmp_peak = (state_q == ST_LO) ? lo_peak_q : hi_peak_q;
	assign cmp_gt   = cmp_cnt > cmp_peak;
	assign cmp_fall = (cmp_cnt < cmp_peak) && (cmp_peak >= accept_q);

	// pass results, with estimates for a one-sided find
	always_comb begin
		fin_ok = lf_q || hf_q;
		if (lf_q) begin
			fin_lo = lo_wall_q;
		end else if (hf_q) begin
			fin_lo = hi_wall_q - OUT_W'(course_q);
		end else begin
			fin_lo = '0;
		end
		if (hf_q) begin
			fin_hi = hi_wall_q;
		end else if (lf_q) begin
			fin_hi = lo_wall_q + OUT_W'(course_q);
		end else begin
			fin_hi = '0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RST;
			course_q     <= COURSE_RST;
			accept_q     <= ACCEPT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q <= cfg_data;
				REG_COURSE_LEN:  course_q     <= cfg_data;
				REG_WALL_ACCEPT: accept_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			row_accum_q <= '0;
			occ_q       <= 1'b0;
			last_q      <= 1'b0;
			hwm_q       <= IDXW'(MAX_GRID - 1);
			clr_q       <= '0;
			sel_col_q   <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			lo_peak_q   <= '0;
			hi_peak_q   <= '0;
			lf_q        <= 1'b0;
			hf_q        <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDXW'(1);
					if (clr_q == hwm_q) begin
						clr_q   <= '0;
						hwm_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						occ_q  <= (cell_value == OCC_CODE);
						last_q <= last_cell;
						if (cell_value == OCC_CODE && row_accum_q != CNT_MAX) begin
							row_accum_q <= row_accum_q + REG_W'(1);
						end
						if (cur_col_q > hwm_q) begin
							hwm_q <= cur_col_q;
						end
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (last_q) begin
						cur_row_q   <= '0;
						cur_col_q   <= '0;
						row_accum_q <= '0;
						sel_col_q   <= 1'b0;
						lo_q        <= '0;
						hi_q        <= IDXW'(weff - WW'(1));
						lo_peak_q   <= '0;
						hi_peak_q   <= '0;
						lf_q        <= 1'b0;
						hf_q        <= 1'b0;
						state_q     <= ST_RND;
					end else if (col_next >= weff) begin
						row_accum_q <= '0;
						cur_col_q   <= '0;
						cur_row_q   <= (row_next >= weff) ? '0 : IDXW'(row_next);
						state_q     <= ST_IDLE;
					end else begin
						cur_col_q <= IDXW'(col_next);
						state_q   <= ST_IDLE;
					end
				end
				ST_RND: begin
					if (!srch_go) begin
						state_q <= ST_FIN;
					end else if (!lf_q) begin
						state_q <= ST_LO;
					end else begin
						state_q <= ST_HI;
					end
				end
				ST_LO: begin
					if (cmp_gt) begin
						lo_peak_q <= cmp_cnt;
					end else if (cmp_fall) begin
						lf_q      <= 1'b1;
						lo_wall_q <= OUT_W'(lo_q) - OUT_W'(1);
					end
					lo_q    <= lo_q + IDXW'(1);
					state_q <= hf_q ? ST_RND : ST_HI;
				end
				ST_HI: begin
					if (cmp_gt) begin
						hi_peak_q <= cmp_cnt;
					end else if (cmp_fall) begin
						hf_q      <= 1'b1;
						hi_wall_q <= OUT_W'(hi_q) + OUT_W'(1);
					end
					if (hi_q != '0) begin
						hi_q <= hi_q - IDXW'(1);
					end
					state_q <= ST_RND;
				end
				ST_FIN: begin
					if (!sel_col_q) begin
						north_q    <= fin_lo;
						north_ok_q <= fin_ok;
						south_q    <= fin_hi;
						south_ok_q <= fin_ok;
						sel_col_q  <= 1'b1;
						lo_q       <= '0;
						hi_q       <= IDXW'(weff - WW'(1));
						lo_peak_q  <= '0;
						hi_peak_q  <= '0;
						lf_q       <= 1'b0;
						hf_q       <= 1'b0;
						state_q    <= ST_RND;
					end else begin
						west_q    <= fin_lo;
						west_ok_q <= fin_ok;
						east_q    <= fin_hi;
						east_ok_q <= fin_ok;
						done_q    <= 1'b1;
						clr_q     <= '0;
						state_q   <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// result ports
	assign done      = done_q;
	assign north_row = $signed(north_q);
	assign north_ok  = north_ok_q;
	assign south_row = $signed(south_q);
	assign south_ok  = south_ok_q;
	assign east_col  = $signed(east_q);
	assign east_ok   = east_ok_q;
	assign west_col  = $signed(west_q);
	assign west_ok   = west_ok_q;

	// checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	a_ok_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (north_ok == south_ok) && (east_ok == west_ok))
		else $error("wall pair validity differs");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

endmodule
`default_nettype wire
